// ===== src/awca_pkg.sv =====
// awca_pkg: shared types and constants of the alpha weighted color adjust block.
// Used by every module under src; depends on nothing.
package awca_pkg;

   localparam int PIX_W         = 32;
   localparam int CH_W          = 8;
   localparam int COORD_W       = 12;
   localparam int CFG_W         = 13;
   localparam int ROW_LIMIT     = 4096;
   localparam int MAX_WIDTH_DEF = 4096;
   localparam int SUM_W         = 10;
   localparam int NUM_W         = 18;
   localparam int STEP_W        = 5;
   localparam int CSR_ADDR_W    = 1;
   localparam int RSP_DATA_W    = 56;

   localparam logic [CSR_ADDR_W-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   typedef struct packed {
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic               adj;
      logic               last_col;
      logic               last_row;
      logic [PIX_W-1:0]   cur;
      logic [PIX_W-1:0]   upper;
      logic [PIX_W-1:0]   upper_left;
      logic [PIX_W-1:0]   left;
   } entry_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_SUM,
      BK_MUL,
      BK_DIV,
      BK_ADJ,
      BK_COL,
      BK_ROW
   } back_state_type;

   function automatic logic [CH_W-1:0] chan(input logic [PIX_W-1:0] px, input int k);
      chan = px[k*CH_W +: CH_W];
   endfunction

endpackage

// ===== src/alpha_weighted_color_adjust.sv =====
// alpha_weighted_color_adjust: top level, joins front, queue and back.
// Depends on awca_pkg, awca_front, awca_fifo, awca_back.
//
//   channel  direction  fields (low bit first)
//   req      in         tdata: in_red, in_green, in_blue, in_alpha
//   rsp      out        tdata: pix_col, pix_row, out_red, out_green, out_blue, out_alpha;
//                       tlast: final_of_run
//   csr      in         csr_addr 0 image_width, 1 image_height
//
// The front takes one pixel per cycle while the two-entry queue has room.
// An adjusted pixel holds the back through pop, sum, multiply and the 18 divide
// steps of the per-channel divider, then through each emitted result.
// A zero alpha sum skips the divide.
// Pixels with no adjusted result hold the back only for the pop and their results; rsp stalls hold each result.
// Reset is synchronous; the row store needs no clearing pass.
module alpha_weighted_color_adjust #(
   parameter int MAX_WIDTH = awca_pkg::MAX_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [awca_pkg::PIX_W-1:0]        req_tdata,  // in_red, in_green, in_blue, in_alpha
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // pix_col, pix_row, out_red, out_green, out_blue, out_alpha
   output logic [awca_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tlast,
   input  logic                              csr_we,
   input  logic [awca_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [awca_pkg::CFG_W-1:0]        csr_wdata
);
   awca_pkg::entry_type f_entry, q_entry;
   logic push, q_full, pop, q_valid;

   awca_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .push       (push),
      .q_full     (q_full),
      .entry      (f_entry)
   );

   awca_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .wr_data   (f_entry),
      .full      (q_full),
      .pop       (pop),
      .not_empty (q_valid),
      .rd_data   (q_entry)
   );

   awca_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_data     (q_entry),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );
endmodule

// ===== src/awca_front.sv =====
// awca_front: position counters, size registers, row store and neighbor registers.
// Classifies each pixel and hands a complete entry to the queue. Depends on awca_pkg.
module awca_front #(
   parameter int MAX_WIDTH = awca_pkg::MAX_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [awca_pkg::PIX_W-1:0]          req_tdata,
   input  logic                                csr_we,
   input  logic [awca_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [awca_pkg::CFG_W-1:0]          csr_wdata,
   output logic                                push,
   input  logic                                q_full,
   output awca_pkg::entry_type                 entry
);
   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = (CW + 1 > awca_pkg::CFG_W) ? CW + 1 : awca_pkg::CFG_W;
   localparam logic [WW-1:0] MAXW = WW'(MAX_WIDTH);
   localparam logic [awca_pkg::CFG_W-1:0] MAXH = awca_pkg::CFG_W'(awca_pkg::ROW_LIMIT);

   logic [awca_pkg::CFG_W-1:0] width_ff, height_ff;
   logic [CW-1:0]              col_ff, col_in;
   logic [awca_pkg::COORD_W-1:0] row_ff, row_in;
   logic [WW-1:0]              w_eff, w_raw, c_ext, c_inc;
   logic [awca_pkg::CFG_W-1:0] h_eff, r1, r_ext, r_inc;
   logic [CW-1:0]              c;
   logic [awca_pkg::COORD_W-1:0] r;
   logic [CW+awca_pkg::COORD_W-1:0] c_wide;
   logic                       accept;
   logic [awca_pkg::PIX_W-1:0] mem [MAX_WIDTH];
   logic [awca_pkg::PIX_W-1:0] upper_ff, left_ff, ul_ff;
   logic                       s2_v_ff;
   logic [awca_pkg::COORD_W-1:0] s2_col_ff, s2_row_ff;
   logic                       s2_adj_ff, s2_lc_ff, s2_lr_ff;
   logic [awca_pkg::PIX_W-1:0] s2_cur_ff;

   always_comb begin
      w_raw = WW'(width_ff);
      if (w_raw == '0) begin
         w_eff = WW'(1);
      end else if (w_raw > MAXW) begin
         w_eff = MAXW;
      end else begin
         w_eff = w_raw;
      end
      if (height_ff == '0) begin
         h_eff = awca_pkg::CFG_W'(1);
      end else if (height_ff > MAXH) begin
         h_eff = MAXH;
      end else begin
         h_eff = height_ff;
      end
      if (WW'(col_ff) >= w_eff) begin
         c  = '0;
         r1 = awca_pkg::CFG_W'(row_ff) + awca_pkg::CFG_W'(1);
      end else begin
         c  = col_ff;
         r1 = awca_pkg::CFG_W'(row_ff);
      end
      r      = (r1 >= h_eff) ? '0 : r1[awca_pkg::COORD_W-1:0];
      c_ext  = WW'(c);
      r_ext  = awca_pkg::CFG_W'(r);
      c_inc  = c_ext + WW'(1);
      r_inc  = r_ext + awca_pkg::CFG_W'(1);
      c_wide = {{awca_pkg::COORD_W{1'b0}}, c};
      if (c_inc >= w_eff) begin
         col_in = '0;
         row_in = (r_inc >= h_eff) ? '0 : r_inc[awca_pkg::COORD_W-1:0];
      end else begin
         col_in = c_inc[CW-1:0];
         row_in = r;
      end
   end

   assign push       = s2_v_ff && !q_full;
   assign req_tready = !s2_v_ff || push;
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= awca_pkg::CFG_W'(awca_pkg::MAX_WIDTH_DEF);
         height_ff <= MAXH;
         col_ff    <= '0;
         row_ff    <= '0;
         s2_v_ff   <= 1'b0;
         left_ff   <= '0;
         ul_ff     <= '0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               awca_pkg::CSR_IMAGE_WIDTH: begin
                  width_ff <= csr_wdata;
               end
               awca_pkg::CSR_IMAGE_HEIGHT: begin
                  height_ff <= csr_wdata;
               end
               default: begin
               end
            endcase
         end
         if (accept) begin
            col_ff  <= col_in;
            row_ff  <= row_in;
            s2_v_ff <= 1'b1;
         end else if (push) begin
            s2_v_ff <= 1'b0;
         end
         if (push) begin
            ul_ff   <= upper_ff;
            left_ff <= s2_cur_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         upper_ff  <= mem[c];
         mem[c]    <= req_tdata;
         s2_cur_ff <= req_tdata;
         s2_col_ff <= c_wide[awca_pkg::COORD_W-1:0];
         s2_row_ff <= r;
         s2_adj_ff <= (r != '0) && (c != '0);
         s2_lc_ff  <= (r != '0) && (c_inc == w_eff);
         s2_lr_ff  <= (r_inc == h_eff);
      end
   end

   always_comb begin
      entry.col        = s2_col_ff;
      entry.row        = s2_row_ff;
      entry.adj        = s2_adj_ff;
      entry.last_col   = s2_lc_ff;
      entry.last_row   = s2_lr_ff;
      entry.cur        = s2_cur_ff;
      entry.upper      = upper_ff;
      entry.upper_left = ul_ff;
      entry.left       = left_ff;
   end
endmodule

// ===== src/awca_fifo.sv =====
// awca_fifo: two-entry queue of classified pixels between front and back.
// Depends on awca_pkg for the entry type.
module awca_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  awca_pkg::entry_type wr_data,
   output logic                full,
   input  logic                pop,
   output logic                not_empty,
   output awca_pkg::entry_type rd_data
);
   awca_pkg::entry_type slot_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;

   assign full      = (cnt_ff == 2'd2);
   assign not_empty = (cnt_ff != 2'd0);
   assign rd_data   = slot_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) begin
            wp_ff <= !wp_ff;
         end
         if (pop) begin
            rp_ff <= !rp_ff;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 2'd1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wp_ff] <= wr_data;
      end
   end
endmodule

// ===== src/awca_back.sv =====
// awca_back: computes the weighted colors with a bit-serial divider per channel
// and emits up to three results per entry through an output register. Depends on awca_pkg.
module awca_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_valid,
   input  awca_pkg::entry_type               q_data,
   output logic                              pop,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [awca_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tlast
);
   awca_pkg::back_state_type state_ff, state_in;
   awca_pkg::entry_type      e_ff;
   logic [awca_pkg::SUM_W-1:0]  sum_ff;
   logic [awca_pkg::SUM_W-1:0]  ax4;
   logic [awca_pkg::NUM_W-1:0]  num_ff [3];
   logic [awca_pkg::SUM_W-1:0]  rem_ff [3];
   logic [awca_pkg::STEP_W-1:0] step_ff;
   logic [awca_pkg::SUM_W:0]    trial [3];
   logic                        ge [3];
   logic                        out_free, load;
   logic [awca_pkg::COORD_W-1:0] o_col, o_row;
   logic [awca_pkg::PIX_W-1:0]  o_pix, adj_pix;
   logic                        o_last;
   logic [awca_pkg::RSP_DATA_W-1:0] o_data_ff;
   logic                        o_v_ff, o_last_ff;

   assign out_free = !o_v_ff || rsp_tready;

   always_comb begin
      ax4 = {awca_pkg::chan(e_ff.upper_left, 3), 2'b00};
      if (ax4 > sum_ff) begin
         ax4 = sum_ff;
      end
      for (int k = 0; k < 3; k++) begin
         trial[k] = {rem_ff[k], num_ff[k][awca_pkg::NUM_W-1]};
         ge[k]    = trial[k] >= {1'b0, sum_ff};
      end
      if (sum_ff == '0) begin
         adj_pix = e_ff.upper_left;
      end else begin
         adj_pix = {awca_pkg::chan(e_ff.upper_left, 3), num_ff[2][7:0],
                    num_ff[1][7:0], num_ff[0][7:0]};
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         awca_pkg::BK_IDLE: begin
            if (q_valid) begin
               if (q_data.adj) begin
                  state_in = awca_pkg::BK_SUM;
               end else if (q_data.last_col) begin
                  state_in = awca_pkg::BK_COL;
               end else if (q_data.last_row) begin
                  state_in = awca_pkg::BK_ROW;
               end
            end
         end
         awca_pkg::BK_SUM: begin
            state_in = awca_pkg::BK_MUL;
         end
         awca_pkg::BK_MUL: begin
            state_in = (sum_ff == '0) ? awca_pkg::BK_ADJ : awca_pkg::BK_DIV;
         end
         awca_pkg::BK_DIV: begin
            if (step_ff == awca_pkg::STEP_W'(awca_pkg::NUM_W - 1)) begin
               state_in = awca_pkg::BK_ADJ;
            end
         end
         awca_pkg::BK_ADJ: begin
            if (out_free) begin
               if (e_ff.last_col) begin
                  state_in = awca_pkg::BK_COL;
               end else if (e_ff.last_row) begin
                  state_in = awca_pkg::BK_ROW;
               end else begin
                  state_in = awca_pkg::BK_IDLE;
               end
            end
         end
         awca_pkg::BK_COL: begin
            if (out_free) begin
               state_in = e_ff.last_row ? awca_pkg::BK_ROW : awca_pkg::BK_IDLE;
            end
         end
         awca_pkg::BK_ROW: begin
            if (out_free) begin
               state_in = awca_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = awca_pkg::BK_IDLE;
         end
      endcase
   end

   always_comb begin
      pop    = 1'b0;
      load   = 1'b0;
      o_col  = e_ff.col;
      o_row  = e_ff.row;
      o_pix  = e_ff.cur;
      o_last = 1'b1;
      case (state_ff)
         awca_pkg::BK_IDLE: begin
            pop = q_valid;
         end
         awca_pkg::BK_ADJ: begin
            load   = out_free;
            o_col  = e_ff.col - awca_pkg::COORD_W'(1);
            o_row  = e_ff.row - awca_pkg::COORD_W'(1);
            o_pix  = adj_pix;
            o_last = !(e_ff.last_col || e_ff.last_row);
         end
         awca_pkg::BK_COL: begin
            load   = out_free;
            o_row  = e_ff.row - awca_pkg::COORD_W'(1);
            o_pix  = e_ff.upper;
            o_last = !e_ff.last_row;
         end
         awca_pkg::BK_ROW: begin
            load = out_free;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= awca_pkg::BK_IDLE;
         o_v_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load) begin
            o_v_ff <= 1'b1;
         end else if (rsp_tready) begin
            o_v_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         e_ff <= q_data;
      end
      if (load) begin
         o_data_ff <= {o_pix, o_row, o_col};
         o_last_ff <= o_last;
      end
      case (state_ff)
         awca_pkg::BK_SUM: begin
            sum_ff <= awca_pkg::SUM_W'(awca_pkg::chan(e_ff.upper_left, 3))
                    + awca_pkg::SUM_W'(awca_pkg::chan(e_ff.upper, 3))
                    + awca_pkg::SUM_W'(awca_pkg::chan(e_ff.left, 3))
                    + awca_pkg::SUM_W'(awca_pkg::chan(e_ff.cur, 3));
         end
         awca_pkg::BK_MUL: begin
            step_ff <= '0;
            for (int k = 0; k < 3; k++) begin
               num_ff[k] <= awca_pkg::NUM_W'(ax4 * awca_pkg::chan(e_ff.upper_left, k));
               rem_ff[k] <= '0;
            end
         end
         awca_pkg::BK_DIV: begin
            step_ff <= step_ff + awca_pkg::STEP_W'(1);
            for (int k = 0; k < 3; k++) begin
               rem_ff[k] <= ge[k] ? awca_pkg::SUM_W'(trial[k] - {1'b0, sum_ff})
                                  : trial[k][awca_pkg::SUM_W-1:0];
               num_ff[k] <= {num_ff[k][awca_pkg::NUM_W-2:0], ge[k]};
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_tvalid = o_v_ff;
   assign rsp_tdata  = o_data_ff;
   assign rsp_tlast  = o_last_ff;
endmodule
